@@ src/morse_symbol_keyer_defines.svh @@
// Assertion macros for the Morse symbol keyer.
`ifndef MORSE_SYMBOL_KEYER_DEFINES_SVH
`define MORSE_SYMBOL_KEYER_DEFINES_SVH

// a holds in the same cycle as b
`define MSK_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: assertion failed");

// a in one cycle implies b in the next
`define MSK_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: assertion failed");

`endif

@@ src/msk_pkg.sv @@
// Shared types, codes and helpers for the Morse symbol keyer.
package msk_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_CODE = 1'd1;

  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 19;
  localparam logic [TIMER_W-1:0] ELAPSED_MAX = 19'h7FFFF;

  localparam logic [15:0] DIT_TICKS_RST  = 16'd100;
  localparam logic [7:0]  SPACE_CODE_RST = 8'hFF;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic key_on;
    logic busy;
    logic dropped;
  } result_t;

  function automatic logic char_done(input logic [7:0] b);
    char_done = (b == 8'h00) || (b == 8'hFF);
  endfunction

endpackage

@@ src/msk_fifo.sv @@
// Character queue with a prefetched head register.
module msk_fifo #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msk_pkg::fifo_ctrl_t   ctrl,
  output msk_pkg::fifo_stat_t   stat,
  output logic [7:0]            head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       head_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (ctrl.clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      count_nxt  = '0;
    end else begin
      if (ctrl.pop) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end
      if (ctrl.push) begin
        wr_ptr_nxt = ptr_inc(wr_ptr_r);
      end
      if (ctrl.push && !ctrl.pop) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      mem[wr_ptr_r] <= ctrl.wdata;
    end
    if (ctrl.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctrl.wdata;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head       = head_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);

endmodule

@@ src/msk_core.sv @@
// Keying state, timers and configuration registers.
module msk_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msk_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              go,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        sym_byte,
  input  msk_pkg::fifo_stat_t               fifo_stat,
  input  logic [7:0]                        fifo_head,
  output msk_pkg::fifo_ctrl_t               fifo_ctrl,
  output msk_pkg::result_t                  res_nxt,
  output logic                              active,
  output logic                              key_state
);

  localparam int TW = msk_pkg::TIMER_W;

  logic [15:0]   dit_r;
  logic [7:0]    space_r;
  logic [7:0]    pattern_r, pattern_nxt;
  logic          tone_r, tone_nxt;
  logic          active_r, active_nxt;
  logic          key_r, key_nxt;
  logic [TW-1:0] wait_r, wait_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;
  logic          lost;

  always_comb begin
    logic [TW-1:0] el_inc;
    logic [TW-1:0] dit1, dit3, dit4, dit8;
    logic [7:0]    pat_w;
    logic [TW-1:0] wl_w;
    el_inc = (elapsed_r == msk_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + TW'(1);
    dit1   = {3'b0, dit_r};
    dit3   = {2'b0, dit_r, 1'b0} + {3'b0, dit_r};
    dit4   = {1'b0, dit_r, 2'b0};
    dit8   = {dit_r, 3'b0};
    pat_w  = pattern_r;
    wl_w   = wait_r;

    pattern_nxt = pattern_r;
    tone_nxt    = tone_r;
    active_nxt  = active_r;
    key_nxt     = key_r;
    wait_nxt    = wait_r;
    elapsed_nxt = elapsed_r;
    lost        = 1'b0;
    fifo_ctrl.push  = 1'b0;
    fifo_ctrl.pop   = 1'b0;
    fifo_ctrl.clear = 1'b0;
    fifo_ctrl.wdata = sym_byte;

    if (go) begin
      case (kind)
        msk_pkg::KIND_BYTE: begin
          if (sym_byte != 8'h00) begin
            if (!active_r) begin
              key_nxt     = 1'b0;
              pattern_nxt = sym_byte;
              tone_nxt    = 1'b0;
              active_nxt  = 1'b1;
              wait_nxt    = '0;
              elapsed_nxt = '0;
            end else if (!fifo_stat.full) begin
              fifo_ctrl.push = 1'b1;
            end else begin
              lost = 1'b1;
            end
          end
        end
        msk_pkg::KIND_TICK: begin
          if (active_r) begin
            if ((wait_r != '0) && (el_inc < wait_r)) begin
              elapsed_nxt = el_inc;
            end else begin
              elapsed_nxt = '0;
              if (tone_r) begin
                tone_nxt = 1'b0;
                wait_nxt = msk_pkg::char_done(pattern_r) ? dit4 : dit1;
                key_nxt  = 1'b0;
              end else if (msk_pkg::char_done(pattern_r) && fifo_stat.empty) begin
                pattern_nxt = '0;
                active_nxt  = 1'b0;
              end else begin
                if (msk_pkg::char_done(pattern_r)) begin
                  pat_w         = fifo_head;
                  fifo_ctrl.pop = 1'b1;
                  if (pat_w == space_r) begin
                    wl_w = dit8;
                  end
                end
                if (!msk_pkg::char_done(pat_w)) begin
                  tone_nxt = 1'b1;
                  wl_w     = pat_w[0] ? dit3 : dit1;
                  key_nxt  = 1'b1;
                  pat_w    = {pat_w[7], pat_w[7:1]};
                end
                pattern_nxt = pat_w;
                wait_nxt    = wl_w;
              end
            end
          end
        end
        msk_pkg::KIND_CLEAR: begin
          fifo_ctrl.clear = 1'b1;
          pattern_nxt = '0;
          tone_nxt    = 1'b0;
          active_nxt  = 1'b0;
          key_nxt     = 1'b0;
          wait_nxt    = '0;
          elapsed_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    res_nxt.key_on  = key_nxt;
    res_nxt.busy    = active_nxt;
    res_nxt.dropped = lost;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_r     <= msk_pkg::DIT_TICKS_RST;
      space_r   <= msk_pkg::SPACE_CODE_RST;
      pattern_r <= '0;
      tone_r    <= 1'b0;
      active_r  <= 1'b0;
      key_r     <= 1'b0;
      wait_r    <= '0;
      elapsed_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          msk_pkg::CFG_DIT_TICKS:  dit_r   <= cfg_wdata;
          msk_pkg::CFG_SPACE_CODE: space_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      pattern_r <= pattern_nxt;
      tone_r    <= tone_nxt;
      active_r  <= active_nxt;
      key_r     <= key_nxt;
      wait_r    <= wait_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign active    = active_r;
  assign key_state = key_r;

endmodule

@@ src/morse_symbol_keyer.sv @@
// Morse symbol keyer: top level with input and result registers.
//
// Input channel (in_valid/in_ready): in_kind 0 carries a packed Morse byte
// in in_symbol_byte (LSB first, 1 = dah, 0 = dit, ends at 0x00 or 0xFF),
// kind 1 is one time tick, kind 2 clears and stops the keyer.
// Every input item gives exactly one result item on the output channel
// (out_valid/out_ready): out_key_on, out_busy_res and out_dropped as they
// stand after that item. Bytes that arrive while busy wait in a queue of
// QUEUE_DEPTH entries; a byte that meets a full queue is flagged dropped.
// An accepted item first sits in the input register; its state update then
// lands in the result register, which drives out_valid. Throughput is one
// item per cycle while out_ready does not hold the result register.
// While out_ready is low the result register holds and the input register
// fills, after which in_ready drops; both resume in the cycle out_ready rises.
// Configuration is written through cfg_we, cfg_index and cfg_wdata:
// index 0 is dit_ticks, index 1 is space_code; write only while idle.
// Synchronous reset (rst_n low) empties the queue, keys off, restores the
// register defaults and leaves both channels empty.
module morse_symbol_keyer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [7:0]                      in_symbol_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_key_on,
  output logic                            out_busy_res,
  output logic                            out_dropped,
  input  logic                            cfg_we,
  input  logic [msk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "morse_symbol_keyer_defines.svh"

  logic                s1_valid_r, s1_valid_nxt;
  logic [1:0]          s1_kind_r;
  logic [7:0]          s1_byte_r;
  logic                s1_go;
  logic                out_valid_r, out_valid_nxt;
  msk_pkg::result_t    res_r, res_nxt;
  msk_pkg::fifo_ctrl_t fifo_ctrl;
  msk_pkg::fifo_stat_t fifo_stat;
  logic [7:0]          fifo_head;
  logic                active;
  logic                key_state;

  assign s1_go         = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_go;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_symbol_byte;
    end
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  msk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (s1_go),
    .kind      (s1_kind_r),
    .sym_byte  (s1_byte_r),
    .fifo_stat (fifo_stat),
    .fifo_head (fifo_head),
    .fifo_ctrl (fifo_ctrl),
    .res_nxt   (res_nxt),
    .active    (active),
    .key_state (key_state)
  );

  msk_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fifo_ctrl),
    .stat  (fifo_stat),
    .head  (fifo_head)
  );

  assign out_valid    = out_valid_r;
  assign out_key_on   = res_r.key_on;
  assign out_busy_res = res_r.busy;
  assign out_dropped  = res_r.dropped;

  // tone only while a message is in progress
  `MSK_ASSERT_SAME(a_key_implies_active, clk, rst_n, key_state, active)
  // queued characters only while busy
  `MSK_ASSERT_SAME(a_queue_implies_active, clk, rst_n, !fifo_stat.empty, active)
  // a dropped byte is only reported while busy
  `MSK_ASSERT_SAME(a_drop_implies_busy, clk, rst_n, out_valid_r && res_r.dropped, res_r.busy)
  // a processed item always lands in the result register
  `MSK_ASSERT_NEXT(a_go_gives_result, clk, rst_n, s1_go, out_valid_r)

endmodule
